FILE: design/fixed_block_pool_allocator_top_defines.svh
// assertion macros shared by the allocator checks
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FAP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fap check failed");

// next-cycle implication, disabled in reset
`define FAP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fap check failed");

`endif

FILE: design/fap_pkg.sv
// types and constants of the fixed block pool allocator
package fap_pkg;

  localparam int ADDR_W    = 16;
  localparam int SIZE_W    = 11;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_CLASSES = 3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_SIZE     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SIZE_SMALL   = 3'd0;
  localparam cfg_idx_t REG_SIZE_MEDIUM  = 3'd1;
  localparam cfg_idx_t REG_SIZE_LARGE   = 3'd2;
  localparam cfg_idx_t REG_COUNT_SMALL  = 3'd3;
  localparam cfg_idx_t REG_COUNT_MEDIUM = 3'd4;
  localparam cfg_idx_t REG_COUNT_LARGE  = 3'd5;

  localparam logic [SIZE_W-1:0]  RST_SIZE_SMALL   = 11'd100;
  localparam logic [SIZE_W-1:0]  RST_SIZE_MEDIUM  = 11'd200;
  localparam logic [SIZE_W-1:0]  RST_SIZE_LARGE   = 11'd500;
  localparam logic [COUNT_W-1:0] RST_COUNT_SMALL  = 4'd5;
  localparam logic [COUNT_W-1:0] RST_COUNT_MEDIUM = 4'd5;
  localparam logic [COUNT_W-1:0] RST_COUNT_LARGE  = 4'd4;

endpackage

FILE: design/fixed_block_pool_allocator_top.sv
// fixed block pool allocator: three size classes, one free bit per block
// an unknown size answers in the cycle after start; otherwise the result follows
//   a block-by-block walk through the classes up to the one that answers
// throughput: one item at a time, set by the single address adder/compare
//   that walks the arena block by block; busy stays high until the result
// done strobes the result for one cycle; the receiver cannot stall
// reset (rst, synchronous): all blocks free, class registers at defaults
module fixed_block_pool_allocator_top #(
  parameter int NUM_CLASSES = 3,
  parameter int MAX_BLOCKS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind,
  input  logic [fap_pkg::SIZE_W-1:0]     request_size,
  input  logic [fap_pkg::ADDR_W-1:0]     block_offset,
  output logic                           done,
  output logic [fap_pkg::ADDR_W-1:0]     granted_offset,
  output logic [1:0]                     status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fap_pkg::SIZE_W-1:0]     cfg_data
);

  localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int JW  = $clog2(MAX_BLOCKS + 1);
  localparam int JIW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  typedef enum logic [0:0] {IDLE, SCAN} state_t;

  state_t                          state;
  logic                            op_free;
  logic [CW-1:0]                   target;
  logic [CW-1:0]                   cls;
  logic [JW-1:0]                   idx;
  logic [fap_pkg::ADDR_W-1:0]      addr;
  logic [fap_pkg::ADDR_W-1:0]      off;
  logic                            hit;
  logic [JIW-1:0]                  hit_idx;
  logic [fap_pkg::ADDR_W-1:0]      hit_addr;
  logic [MAX_BLOCKS-1:0]           free_map [NUM_CLASSES];
  logic [fap_pkg::SIZE_W-1:0]      size_r   [fap_pkg::CFG_CLASSES];
  logic [fap_pkg::COUNT_W-1:0]     count_r  [fap_pkg::CFG_CLASSES];

  logic [fap_pkg::SIZE_W-1:0]      cur_size;
  logic [JW-1:0]                   cur_n;
  logic                            in_class;
  logic                            last_cls;
  logic                            blk_free;
  logic [fap_pkg::ADDR_W-1:0]      addr_sum;
  logic                            alloc_found;
  logic [CW-1:0]                   alloc_tgt;

  assign busy      = (state != IDLE);
  // a class register never changes under a command being taken
  assign cfg_ready = (state == IDLE) && !start;

  // lowest class whose size equals the request
  always_comb begin
    alloc_found = 1'b0;
    alloc_tgt   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (size_r[c] == request_size) begin
        alloc_found = 1'b1;
        alloc_tgt   = CW'(c);
      end
    end
  end

  always_comb begin
    cur_size = size_r[cls];
    if (count_r[cls] > fap_pkg::COUNT_W'(MAX_BLOCKS)) begin
      cur_n = JW'(MAX_BLOCKS);
    end else begin
      cur_n = count_r[cls][JW-1:0];
    end
    in_class = (idx < cur_n);
    last_cls = (cls == CW'(NUM_CLASSES - 1));
    blk_free = free_map[cls][idx[JIW-1:0]];
    // the one shared adder walks block offsets through the arena
    addr_sum = addr + {{(fap_pkg::ADDR_W - fap_pkg::SIZE_W){1'b0}}, cur_size};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      done           <= 1'b0;
      hit            <= 1'b0;
      granted_offset <= '0;
      status         <= fap_pkg::ST_OK;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_map[c] <= '1;
      end
      size_r[0]  <= fap_pkg::RST_SIZE_SMALL;
      size_r[1]  <= fap_pkg::RST_SIZE_MEDIUM;
      size_r[2]  <= fap_pkg::RST_SIZE_LARGE;
      count_r[0] <= fap_pkg::RST_COUNT_SMALL;
      count_r[1] <= fap_pkg::RST_COUNT_MEDIUM;
      count_r[2] <= fap_pkg::RST_COUNT_LARGE;
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fap_pkg::REG_SIZE_SMALL:   size_r[0]  <= cfg_data;
          fap_pkg::REG_SIZE_MEDIUM:  size_r[1]  <= cfg_data;
          fap_pkg::REG_SIZE_LARGE:   size_r[2]  <= cfg_data;
          fap_pkg::REG_COUNT_SMALL:  count_r[0] <= cfg_data[fap_pkg::COUNT_W-1:0];
          fap_pkg::REG_COUNT_MEDIUM: count_r[1] <= cfg_data[fap_pkg::COUNT_W-1:0];
          fap_pkg::REG_COUNT_LARGE:  count_r[2] <= cfg_data[fap_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end

      case (state)
        IDLE: begin
          if (start) begin
            op_free <= kind;
            off     <= block_offset;
            target  <= alloc_tgt;
            cls     <= '0;
            idx     <= '0;
            addr    <= '0;
            hit     <= 1'b0;
            if (kind == fap_pkg::KIND_ALLOC && !alloc_found) begin
              done           <= 1'b1;
              status         <= fap_pkg::ST_SIZE;
              granted_offset <= '0;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (in_class) begin
            addr <= addr_sum;
            idx  <= idx + JW'(1);
            // keep the highest matching block of the class
            if (op_free) begin
              if (addr == off) begin
                hit     <= 1'b1;
                hit_idx <= idx[JIW-1:0];
              end
            end else if (cls == target && blk_free) begin
              hit      <= 1'b1;
              hit_idx  <= idx[JIW-1:0];
              hit_addr <= addr;
            end
          end else if (hit) begin
            free_map[cls][hit_idx] <= op_free;
            granted_offset         <= op_free ? '0 : hit_addr;
            status                 <= fap_pkg::ST_OK;
            done                   <= 1'b1;
            state                  <= IDLE;
          end else if (!op_free && cls == target) begin
            granted_offset <= '0;
            status         <= fap_pkg::ST_FULL;
            done           <= 1'b1;
            state          <= IDLE;
          end else if (last_cls) begin
            granted_offset <= '0;
            status         <= fap_pkg::ST_NOTFOUND;
            done           <= 1'b1;
            state          <= IDLE;
          end else begin
            cls <= cls + CW'(1);
            idx <= '0;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: design/fap_checker.sv
// port-level checks for the allocator, bound to the top level
`include "fixed_block_pool_allocator_top_defines.svh"

module fap_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [fap_pkg::ADDR_W-1:0]    granted_offset,
  input logic [1:0]                    status
);

  // a result frees the block for the next command in the same cycle
  `FAP_ASSERT_NOW(a_done_not_busy, clk, rst, done, !busy)

  // an accepted command either starts a walk or answers without one
  `FAP_ASSERT_NEXT(a_start_moves, clk, rst, start && !busy, busy || done)

  // busy only ends with a result transfer
  `FAP_ASSERT_NEXT(a_busy_ends_done, clk, rst, busy, busy || done)

  // failed requests carry no offset
  `FAP_ASSERT_NOW(a_fail_zero, clk, rst, done && status != fap_pkg::ST_OK, granted_offset == '0)

endmodule

bind fixed_block_pool_allocator_top fap_checker u_fap_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .granted_offset (granted_offset),
  .status         (status)
);
